FILE: sv/wvd_pkg.sv
// Package for the windowed volume dispersion unit.
// Holds the transaction payload types, field widths and fixed constants.
// No dependencies.
package wvd_pkg;

  localparam int VOL_W    = 24;
  localparam int FEAT_W   = 20;
  localparam int FRAC_W   = 16;
  localparam int WL_W     = 9;
  localparam int FEAT_SCALE = 10;
  localparam int MIN_BARS = 3;

  localparam logic [WL_W-1:0]   DEFAULT_WINDOW = 9'd64;
  localparam logic [WL_W-1:0]   MIN_WINDOW     = 9'd2;
  localparam logic [FEAT_W-1:0] FEATURE_MAX    = 20'd655360;

  typedef enum logic {
    OP_APPEND  = 1'b0,
    OP_REPLACE = 1'b1
  } op_e;

  typedef struct packed {
    op_e              operation;
    logic [VOL_W-1:0] volume;
  } in_t;

  typedef struct packed {
    logic [FEAT_W-1:0] feature;
    logic              feature_valid;
  } out_t;

endpackage

FILE: sv/wvd_mul.sv
// Iterative shift-add multiplier, one multiplier bit per cycle.
// Used for S1*S1 and k*S2. Depends on nothing.
module wvd_mul #(
  parameter int PW = 72,
  parameter int BW = 36
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [PW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic          done_o,
  output logic [PW-1:0] p_o
);

  logic          busy_q;
  logic [PW-1:0] a_q;
  logic [BW-1:0] b_q;
  logic [PW-1:0] p_q;

  assign done_o = busy_q && (b_q == '0);
  assign p_o    = p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      p_q <= '0;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        p_q <= p_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

endmodule

FILE: sv/wvd_div.sv
// Restoring divider for floor(10 * 2^16 * num / den) with num < den.
// One quotient bit per cycle. Depends on wvd_pkg.
module wvd_div #(
  parameter int DW = 72
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [DW-1:0]              num_i,
  input  logic [DW-1:0]              den_i,
  output logic                       done_o,
  output logic [wvd_pkg::FEAT_W-1:0] q_o
);

  localparam int SH = wvd_pkg::FEAT_W - wvd_pkg::FRAC_W;
  localparam int TW = DW + SH;
  localparam int CW = $clog2(wvd_pkg::FEAT_W + 1);

  logic                       busy_q;
  logic [CW-1:0]              cnt_q;
  logic [DW-1:0]              r_q;
  logic [DW-1:0]              den_q;
  logic [wvd_pkg::FEAT_W-1:0] lo_q;
  logic [wvd_pkg::FEAT_W-1:0] q_q;
  logic [TW-1:0]              scaled;
  logic [DW:0]                rr;
  logic                       fits;

  assign scaled = TW'(num_i) * TW'(wvd_pkg::FEAT_SCALE);
  assign rr     = {r_q, lo_q[wvd_pkg::FEAT_W-1]};
  assign fits   = rr >= {1'b0, den_q};
  assign done_o = busy_q && (cnt_q == CW'(wvd_pkg::FEAT_W));
  assign q_o    = q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= scaled[TW-1:SH];
      lo_q  <= {scaled[SH-1:0], wvd_pkg::FRAC_W'(0)};
      den_q <= den_i;
      q_q   <= '0;
    end else if (busy_q && !done_o) begin
      r_q  <= fits ? DW'(rr - {1'b0, den_q}) : rr[DW-1:0];
      q_q  <= {q_q[wvd_pkg::FEAT_W-2:0], fits};
      lo_q <= lo_q << 1;
    end
  end

endmodule

FILE: sv/windowed_volume_dispersion_unit.sv
// Windowed volume dispersion unit: top level with the bar ring memory,
// the window walk and the result sequencer. Depends on wvd_pkg, wvd_mul
// and wvd_div.
//
// Usage: each input transaction carries an operation (append a new bar or
// replace the newest bar) and a 24-bit volume. Each input transaction
// yields exactly one output transaction: feature, the squared coefficient
// of variation of the last k bars times 10, clamped to 10, in Q16, and
// feature_valid, set once three bars have been seen.
// window_length is written through cfg_we_i/cfg_data_i while idle; the user
// must keep to this, as the block itself does not enforce it. For an input
// with at least three bars the walk reads one ring entry per cycle from a
// single-port memory; then, unless S1 is zero, the shift-add multiplier
// forms S1*S1 and k*S2, and unless the result clamps, the divider forms the
// quotient. The next input is accepted in the cycle after the result is
// registered. One transaction is in work at a time. Reset empties the ring
// (no bars), restores window_length to 64 and needs no clearing pass. A
// result waits in the output register while the receiver stalls; the next
// input is taken meanwhile but its result is held until the register frees.
module windowed_volume_dispersion_unit #(
  parameter int WINDOW_MAX = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  wvd_pkg::in_t             in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output wvd_pkg::out_t            out_data_o,
  input  logic                     cfg_we_i,
  input  logic [wvd_pkg::WL_W-1:0] cfg_data_i
);

  localparam int AW   = $clog2(WINDOW_MAX);
  localparam int KW   = $clog2(WINDOW_MAX + 1);
  localparam int BSW  = $clog2(WINDOW_MAX + 2);
  localparam int NW0  = (wvd_pkg::WL_W > KW) ? wvd_pkg::WL_W : KW;
  localparam int NW   = (NW0 > BSW) ? NW0 : BSW;
  localparam int SW   = wvd_pkg::VOL_W + KW;
  localparam int S2W  = 2 * wvd_pkg::VOL_W + KW;
  localparam int DW   = 2 * SW;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SETUP    = 4'd1;
  localparam logic [3:0] S_WALK     = 4'd2;
  localparam logic [3:0] S_DEN_GO   = 4'd3;
  localparam logic [3:0] S_DEN_WAIT = 4'd4;
  localparam logic [3:0] S_NUM_GO   = 4'd5;
  localparam logic [3:0] S_NUM_WAIT = 4'd6;
  localparam logic [3:0] S_CMP      = 4'd7;
  localparam logic [3:0] S_DIV_GO   = 4'd8;
  localparam logic [3:0] S_DIV_WAIT = 4'd9;
  localparam logic [3:0] S_FINISH   = 4'd10;

  logic [3:0]               state_q;
  logic [AW-1:0]            wr_slot_q;
  logic [BSW-1:0]           bars_q;
  logic [wvd_pkg::WL_W-1:0] wl_q;
  logic                     out_valid_q;
  logic [KW-1:0]            rem_q;
  logic                     rv_q;
  logic                     sv_q;

  logic [wvd_pkg::VOL_W-1:0]   ring_mem [WINDOW_MAX];
  logic [wvd_pkg::VOL_W-1:0]   rd_data_q;
  logic [AW-1:0]               rd_addr_q;
  logic [KW-1:0]               k_q;
  logic [2*wvd_pkg::VOL_W-1:0] sq_q;
  logic [wvd_pkg::VOL_W-1:0]   vol2_q;
  logic [SW-1:0]               s1_q;
  logic [S2W-1:0]              s2_q;
  logic [DW-1:0]               den_q;
  logic [DW-1:0]               num_q;
  wvd_pkg::out_t               res_q;
  wvd_pkg::out_t               out_q;

  logic                     accept;
  logic                     replace;
  logic [AW-1:0]            wr_addr;
  logic                     rd_en;
  logic                     walk_done;
  logic                     out_free;
  logic [wvd_pkg::WL_W-1:0] wl_eff;
  logic [NW-1:0]            n_cap;
  logic [NW-1:0]            last;
  logic [NW-1:0]            k_sel;
  logic                     mul_start;
  logic [DW-1:0]            mul_a;
  logic [SW-1:0]            mul_b;
  logic                     mul_done;
  logic [DW-1:0]            mul_p;
  logic                     div_start;
  logic                     div_done;
  logic [wvd_pkg::FEAT_W-1:0] div_q;

  function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] s);
    prev_slot = (s == '0) ? AW'(WINDOW_MAX - 1) : s - 1'b1;
  endfunction

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
    next_slot = (s == AW'(WINDOW_MAX - 1)) ? '0 : s + 1'b1;
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign replace     = (in_data_i.operation == wvd_pkg::OP_REPLACE) && (bars_q != '0);
  assign wr_addr     = replace ? prev_slot(wr_slot_q) : wr_slot_q;
  assign rd_en       = (state_q == S_WALK) && (rem_q != '0);
  assign walk_done   = (state_q == S_WALK) && (rem_q == '0) && !rv_q && !sv_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign wl_eff = (wl_q < wvd_pkg::MIN_WINDOW) ? wvd_pkg::DEFAULT_WINDOW : wl_q;
  assign n_cap  = (NW'(wl_eff) > NW'(WINDOW_MAX)) ? NW'(WINDOW_MAX) : NW'(wl_eff);
  assign last   = NW'(bars_q - 1'b1);
  assign k_sel  = (n_cap < last) ? n_cap : last;

  assign mul_start = (state_q == S_DEN_GO) && (s1_q != '0) || (state_q == S_NUM_GO);
  assign mul_a     = (state_q == S_NUM_GO) ? DW'(s2_q) : DW'(s1_q);
  assign mul_b     = (state_q == S_NUM_GO) ? SW'(k_q) : s1_q;
  assign div_start = (state_q == S_DIV_GO);

  wvd_mul #(
    .PW(DW),
    .BW(SW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  wvd_div #(
    .DW(DW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_q),
    .den_i  (den_q),
    .done_o (div_done),
    .q_o    (div_q)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ring_mem[wr_addr] <= in_data_i.volume;
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[rd_addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_slot_q   <= '0;
      bars_q      <= '0;
      wl_q        <= wvd_pkg::DEFAULT_WINDOW;
      out_valid_q <= 1'b0;
      rem_q       <= '0;
      rv_q        <= 1'b0;
      sv_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        wl_q <= cfg_data_i;
      end
      rv_q <= rd_en;
      sv_q <= rv_q;
      if ((state_q == S_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (!replace) begin
              wr_slot_q <= next_slot(wr_slot_q);
              if (bars_q != BSW'(WINDOW_MAX + 1)) begin
                bars_q <= bars_q + 1'b1;
              end
            end
            state_q <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (bars_q < BSW'(wvd_pkg::MIN_BARS)) begin
            state_q <= S_FINISH;
          end else begin
            rem_q   <= KW'(k_sel);
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          if (rd_en) begin
            rem_q <= rem_q - 1'b1;
          end
          if (walk_done) begin
            state_q <= S_DEN_GO;
          end
        end
        S_DEN_GO: begin
          state_q <= (s1_q == '0) ? S_FINISH : S_DEN_WAIT;
        end
        S_DEN_WAIT: begin
          if (mul_done) begin
            state_q <= S_NUM_GO;
          end
        end
        S_NUM_GO: begin
          state_q <= S_NUM_WAIT;
        end
        S_NUM_WAIT: begin
          if (mul_done) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          state_q <= (num_q >= den_q) ? S_FINISH : S_DIV_GO;
        end
        S_DIV_GO: begin
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rv_q) begin
      sq_q   <= rd_data_q * rd_data_q;
      vol2_q <= rd_data_q;
    end
    if (sv_q) begin
      s1_q <= s1_q + SW'(vol2_q);
      s2_q <= s2_q + S2W'(sq_q);
    end
    if (rd_en) begin
      rd_addr_q <= prev_slot(rd_addr_q);
    end
    unique case (state_q)
      S_SETUP: begin
        k_q                 <= KW'(k_sel);
        rd_addr_q           <= prev_slot(wr_slot_q);
        s1_q                <= '0;
        s2_q                <= '0;
        res_q.feature       <= '0;
        res_q.feature_valid <= (bars_q >= BSW'(wvd_pkg::MIN_BARS));
      end
      S_DEN_WAIT: begin
        if (mul_done) begin
          den_q <= mul_p;
        end
      end
      S_NUM_WAIT: begin
        if (mul_done) begin
          num_q <= mul_p - den_q;
        end
      end
      S_CMP: begin
        if (num_q >= den_q) begin
          res_q.feature <= wvd_pkg::FEATURE_MAX;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          res_q.feature <= div_q;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_q <= res_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: test/wvd_checker.sv
// Checker for the windowed volume dispersion unit: watches the input, output and
// config ports, predicts each result transaction and compares it field by field.
// Depends on wvd_pkg.
module wvd_checker #(
  parameter int WINDOW_MAX = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  wvd_pkg::in_t             in_data_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  wvd_pkg::out_t            out_data_i,
  input  logic                     cfg_we_i,
  input  logic [wvd_pkg::WL_W-1:0] cfg_data_i,
  output int unsigned              mismatch_count_o,
  output int unsigned              pending_count_o
);

  logic [wvd_pkg::VOL_W-1:0] bar_hist [WINDOW_MAX];
  int unsigned               next_slot;
  int unsigned               bar_count;
  logic [wvd_pkg::WL_W-1:0]  window_len;
  wvd_pkg::out_t             dispersion_q [$];
  wvd_pkg::out_t             expected_res;
  int unsigned               mismatches;

  function automatic wvd_pkg::out_t predict_dispersion(wvd_pkg::in_t item);
    wvd_pkg::out_t res;
    int unsigned   n;
    int unsigned   k;
    int unsigned   slot;
    logic [63:0]   s1;
    logic [63:0]   s2;
    logic [127:0]  num;
    logic [127:0]  den;
    logic [127:0]  frac;
    if (item.operation == wvd_pkg::OP_REPLACE && bar_count != 0) begin
      bar_hist[(next_slot + WINDOW_MAX - 1) % WINDOW_MAX] = item.volume;
    end else begin
      bar_hist[next_slot] = item.volume;
      next_slot = (next_slot + 1) % WINDOW_MAX;
      if (bar_count < WINDOW_MAX + 1) bar_count++;
    end
    res = '0;
    if (bar_count < wvd_pkg::MIN_BARS) return res;
    res.feature_valid = 1'b1;
    n = window_len;
    if (n < wvd_pkg::MIN_WINDOW) n = wvd_pkg::DEFAULT_WINDOW;
    if (n > WINDOW_MAX) n = WINDOW_MAX;
    k = (n < bar_count - 1) ? n : bar_count - 1;
    s1 = '0;
    s2 = '0;
    slot = next_slot;
    for (int i = 0; i < k; i++) begin
      slot = (slot + WINDOW_MAX - 1) % WINDOW_MAX;
      s1 += 64'(bar_hist[slot]);
      s2 += 64'(bar_hist[slot]) * 64'(bar_hist[slot]);
    end
    if (s1 == 0) return res;
    den = 128'(s1) * 128'(s1);
    num = 128'(k) * 128'(s2) - den;
    if (num >= den) begin
      res.feature = wvd_pkg::FEATURE_MAX;
    end else begin
      frac = (num * 128'(wvd_pkg::FEATURE_MAX)) / den;
      res.feature = frac[wvd_pkg::FEAT_W-1:0];
    end
    return res;
  endfunction

  task automatic note_mismatch(string what, wvd_pkg::out_t exp_res, wvd_pkg::out_t act_res);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected feature=%0d valid=%0b, actual feature=%0d valid=%0b",
               what, exp_res.feature, exp_res.feature_valid,
               act_res.feature, act_res.feature_valid);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_slot = 0;
      bar_count = 0;
      window_len = wvd_pkg::DEFAULT_WINDOW;
      dispersion_q.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_count_o <= 0;
    end else begin
      if (cfg_we_i) window_len = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        if (dispersion_q.size() == 0) begin
          note_mismatch("no transaction outstanding", '0, out_data_i);
        end else begin
          expected_res = dispersion_q.pop_front();
          if (out_data_i.feature !== expected_res.feature ||
              out_data_i.feature_valid !== expected_res.feature_valid) begin
            note_mismatch("result", expected_res, out_data_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) dispersion_q.push_back(predict_dispersion(in_data_i));
      mismatch_count_o <= mismatches;
      pending_count_o <= dispersion_q.size();
    end
  end

endmodule

FILE: test/windowed_volume_dispersion_unit_tb.sv
// Top of the windowed volume dispersion unit testbench: clock, reset, stimulus,
// config phases, watchdog and verdict. Depends on wvd_pkg, wvd_checker and the block.
module windowed_volume_dispersion_unit_tb;

  localparam int WINDOW_MAX  = 256;
  localparam int ITEMS_PER_PHASE = 65;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 400;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  wvd_pkg::in_t             in_data_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  wvd_pkg::out_t            out_data_o;
  logic                     cfg_we_i;
  logic [wvd_pkg::WL_W-1:0] cfg_data_i;

  int unsigned               mismatch_count;
  int unsigned               pending_count;
  int unsigned               stall_cycles;
  bit                        idle_on;
  bit                        zero_bias;
  logic [wvd_pkg::VOL_W-1:0] level;

  windowed_volume_dispersion_unit #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  wvd_checker #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .in_data_i       (in_data_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_data_i      (out_data_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= idle_on ? ($urandom_range(0, 99) >= 37) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("windowed_volume_dispersion_unit_tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_bar(input wvd_pkg::op_e op, input logic [wvd_pkg::VOL_W-1:0] vol);
    if (idle_on && $urandom_range(0, 99) < 37) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 37);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{operation: op, volume: vol};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  task automatic set_window(input logic [wvd_pkg::WL_W-1:0] len);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_data_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [wvd_pkg::VOL_W-1:0] pick_volume();
    if (zero_bias && $urandom_range(0, 1) == 0) return '0;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return wvd_pkg::VOL_W'($urandom_range(0, 3));
      2:       return {wvd_pkg::VOL_W{1'b1}} - wvd_pkg::VOL_W'($urandom_range(0, 3));
      3, 4, 5: return level + wvd_pkg::VOL_W'($urandom_range(0, 15));
      default: return wvd_pkg::VOL_W'($urandom);
    endcase
  endfunction

  int unsigned phase_window [10] = '{2, 256, 0, 511, 3, 1, 257, 64, 0, 255};

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    idle_on = 1'b1;
    zero_bias = 1'b0;
    level = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default window after reset; replace on an empty ring appends
    send_bar(wvd_pkg::OP_REPLACE, 24'd5);
    send_bar(wvd_pkg::OP_APPEND, 24'd0);
    send_bar(wvd_pkg::OP_APPEND, 24'd0);
    send_bar(wvd_pkg::OP_REPLACE, 24'hFFFFFF);
    send_bar(wvd_pkg::OP_APPEND, 24'd0);
    send_bar(wvd_pkg::OP_APPEND, 24'd0);
    send_bar(wvd_pkg::OP_APPEND, 24'hFFFFFF);
    send_bar(wvd_pkg::OP_APPEND, 24'hFFFFFF);
    send_bar(wvd_pkg::OP_REPLACE, 24'd1);
    send_bar(wvd_pkg::OP_APPEND, 24'h800000);
    send_bar(wvd_pkg::OP_APPEND, 24'h7FFFFF);
    set_window(9'd2);
    send_bar(wvd_pkg::OP_APPEND, 24'd100);
    send_bar(wvd_pkg::OP_APPEND, 24'd100);
    send_bar(wvd_pkg::OP_APPEND, 24'd0);
    send_bar(wvd_pkg::OP_APPEND, 24'd0);
    send_bar(wvd_pkg::OP_REPLACE, 24'hFFFFFF);
    set_window(9'd1);
    send_bar(wvd_pkg::OP_APPEND, 24'd55);
    send_bar(wvd_pkg::OP_APPEND, 24'hAAAAAA);
    set_window(9'd511);
    send_bar(wvd_pkg::OP_APPEND, 24'h555555);
    send_bar(wvd_pkg::OP_REPLACE, 24'd1);

    for (int p = 0; p < 10; p++) begin
      set_window((p == 8) ? wvd_pkg::WL_W'($urandom_range(0, 511))
                          : wvd_pkg::WL_W'(phase_window[p]));
      idle_on = (p != 3);
      zero_bias = (phase_window[p] == 2 || phase_window[p] == 3);
      level = wvd_pkg::VOL_W'($urandom_range(0, 24'hFFFFF0));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 5 && i == 30) wait_drained();
        send_bar(($urandom_range(0, 3) == 0) ? wvd_pkg::OP_REPLACE : wvd_pkg::OP_APPEND,
                 pick_volume());
      end
    end

    idle_on = 1'b1;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("windowed_volume_dispersion_unit_tb OK");
    end else begin
      $display("windowed_volume_dispersion_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/wvd_pkg.sv
sv/wvd_mul.sv
sv/wvd_div.sv
sv/windowed_volume_dispersion_unit.sv
test/wvd_checker.sv
test/windowed_volume_dispersion_unit_tb.sv
